@@ sv/cle_pkg.sv @@
// shared types and key and result codes for the console line editor
package cle_pkg;

  // control key bytes
  localparam logic [7:0] KEY_NUL    = 8'h00;
  localparam logic [7:0] KEY_DEL    = 8'h7f;
  localparam logic [7:0] KEY_CR     = 8'h0d;
  localparam logic [7:0] KEY_LF     = 8'h0a;
  localparam logic [7:0] KEY_CTRL_D = 8'h04;
  localparam logic [7:0] KEY_CTRL_U = 8'h15;
  localparam logic [7:0] KEY_CTRL_H = 8'h08;

  // request operations
  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // result kinds
  localparam logic [2:0] KIND_ECHO  = 3'd0;
  localparam logic [2:0] KIND_ERASE = 3'd1;
  localparam logic [2:0] KIND_DATA  = 3'd2;
  localparam logic [2:0] KIND_EMPTY = 3'd3;
  localparam logic [2:0] KIND_EOF   = 3'd4;

  // largest erase count a result can carry
  localparam logic [7:0] ERASE_MAX = 8'd255;

  // sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_RD
  } state_t;

endpackage

@@ sv/cle_ram.sv @@
// generic single-write single-read ram with registered read data
module cle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/console_line_editor_core.sv @@
// Console line editor: canonical terminal line discipline over a ring of
// DEPTH received bytes held in a synchronous ram, with read, commit and edit
// indices kept modulo 2*DEPTH. Key requests (op 0) are edited into the
// uncommitted line and echoed; read requests (op 1) hand out committed bytes.
// A key request or a read that finds the ring empty is answered straight from
// the idle state; a read that finds data waits in the read state for the
// registered read data of the line ram. At most one result comes per request,
// held in an output register, so a new request is taken in the cycle the
// previous result leaves, but none while a read waits in the read state. Ring
// contents are not cleared at reset; only committed entries, which were
// written first, are ever read.
module console_line_editor_core #(
  parameter int DEPTH = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_op,
  input  logic [7:0] in_key_byte,
  input  logic       in_first_of_read,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_kind,
  output logic [7:0] out_value,
  output logic [7:0] out_erase_count,
  output logic       out_line_end
);
  import cle_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int IW = $clog2(2 * DEPTH);
  localparam logic [IW:0]   SPAN      = (IW + 1)'(2 * DEPTH);
  localparam logic [IW-1:0] DEPTH_I   = IW'(DEPTH);
  localparam logic [IW-1:0] DEPTH_M1  = IW'(DEPTH - 1);
  localparam logic [IW-1:0] SPAN_M1   = IW'(2 * DEPTH - 1);
  localparam logic [IW-1:0] IDX_ZERO  = '0;
  localparam logic [IW-1:0] IDX_ONE   = IW'(1);

  // ring index helpers
  function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] a);
    return (a == SPAN_M1) ? IDX_ZERO : a + IDX_ONE;
  endfunction

  function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] a);
    return (a == IDX_ZERO) ? SPAN_M1 : a - IDX_ONE;
  endfunction

  function automatic logic [IW-1:0] idx_diff(input logic [IW-1:0] a,
                                             input logic [IW-1:0] b);
    logic [IW:0] d;
    d = {1'b0, a} - {1'b0, b};
    if (d[IW]) begin
      d = d + SPAN;
    end
    return d[IW-1:0];
  endfunction

  function automatic logic [AW-1:0] idx_slot(input logic [IW-1:0] a);
    logic [IW-1:0] s;
    s = (a >= DEPTH_I) ? a - DEPTH_I : a;
    return s[AW-1:0];
  endfunction

  function automatic logic [7:0] sat_count(input logic [IW-1:0] n);
    logic [IW+7:0] w;
    w = {8'b0, n};
    return (w > (IW + 8)'(ERASE_MAX)) ? ERASE_MAX : w[7:0];
  endfunction

  state_t state_r, state_nxt;

  logic [IW-1:0] read_idx_r, read_idx_nxt;
  logic [IW-1:0] commit_idx_r, commit_idx_nxt;
  logic [IW-1:0] edit_idx_r, edit_idx_nxt;
  logic          first_r;

  logic          out_valid_r, out_valid_nxt;
  logic [2:0]    out_kind_r, out_kind_nxt;
  logic [7:0]    out_value_r, out_value_nxt;
  logic [7:0]    out_count_r, out_count_nxt;
  logic          out_lend_r, out_lend_nxt;

  logic          slot_free;
  logic          acc;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  logic [IW-1:0] uncommitted;
  logic [IW-1:0] fill;
  logic [7:0]    key_char;

  // line ring storage
  cle_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_line_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(idx_slot(read_idx_r)),
    .rdata(ram_rdata)
  );

  // handshake
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && slot_free;
  assign acc       = in_valid && in_ready;

  assign uncommitted = idx_diff(edit_idx_r, commit_idx_r);
  assign fill        = idx_diff(edit_idx_r, read_idx_r);
  assign key_char    = (in_key_byte == KEY_CR) ? KEY_LF : in_key_byte;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc && in_op == OP_READ && read_idx_r != commit_idx_r) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // request processing and result selection
  always_comb begin
    read_idx_nxt   = read_idx_r;
    commit_idx_nxt = commit_idx_r;
    edit_idx_nxt   = edit_idx_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_waddr      = idx_slot(edit_idx_r);
    ram_wdata      = key_char;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_kind_nxt   = out_kind_r;
    out_value_nxt  = out_value_r;
    out_count_nxt  = out_count_r;
    out_lend_nxt   = out_lend_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          out_value_nxt = 8'd0;
          out_count_nxt = 8'd0;
          out_lend_nxt  = 1'b0;
          if (in_op == OP_READ) begin
            // read: empty answers at once, otherwise fetch the byte
            if (read_idx_r == commit_idx_r) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_EMPTY;
            end else begin
              ram_re = 1'b1;
            end
          end else if (in_key_byte == KEY_CTRL_U) begin
            // kill the uncommitted line
            if (uncommitted != IDX_ZERO) begin
              edit_idx_nxt  = commit_idx_r;
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_ERASE;
              out_count_nxt = sat_count(uncommitted);
            end
          end else if (in_key_byte == KEY_CTRL_H || in_key_byte == KEY_DEL) begin
            // erase one byte
            if (uncommitted != IDX_ZERO) begin
              edit_idx_nxt  = idx_dec(edit_idx_r);
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_ERASE;
              out_count_nxt = 8'd1;
            end
          end else if (in_key_byte != KEY_NUL && fill < DEPTH_I) begin
            // store and echo, commit on line end, eof or full ring
            ram_we        = 1'b1;
            edit_idx_nxt  = idx_inc(edit_idx_r);
            if (key_char == KEY_LF || key_char == KEY_CTRL_D || fill == DEPTH_M1) begin
              commit_idx_nxt = idx_inc(edit_idx_r);
            end
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_ECHO;
            out_value_nxt = key_char;
          end
        end
      end
      ST_RD: begin
        // fetched byte is back from the ram
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = 8'd0;
          if (ram_rdata == KEY_CTRL_D) begin
            if (first_r) begin
              read_idx_nxt = idx_inc(read_idx_r);
            end
            out_kind_nxt  = KIND_EOF;
            out_value_nxt = 8'd0;
            out_lend_nxt  = 1'b0;
          end else begin
            read_idx_nxt  = idx_inc(read_idx_r);
            out_kind_nxt  = KIND_DATA;
            out_value_nxt = ram_rdata;
            out_lend_nxt  = (ram_rdata == KEY_LF);
          end
        end
      end
      default: begin
        out_valid_nxt = out_valid_r && !out_ready;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      read_idx_r   <= IDX_ZERO;
      commit_idx_r <= IDX_ZERO;
      edit_idx_r   <= IDX_ZERO;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      read_idx_r   <= read_idx_nxt;
      commit_idx_r <= commit_idx_nxt;
      edit_idx_r   <= edit_idx_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (acc) begin
      first_r <= in_first_of_read;
    end
    out_kind_r  <= out_kind_nxt;
    out_value_r <= out_value_nxt;
    out_count_r <= out_count_nxt;
    out_lend_r  <= out_lend_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_value       = out_value_r;
  assign out_erase_count = out_count_r;
  assign out_line_end    = out_lend_r;

endmodule
